// ===== design/pfla_pkg.sv =====
package pfla_pkg;

    localparam int PAGE_W    = 8;
    localparam int SLOT_W    = 10;
    localparam int HANDLE_W  = PAGE_W + SLOT_W;
    localparam int SPP_W     = 11;
    localparam int CLAIMED_W = 9;
    localparam int STATUS_W  = 2;
    localparam int MAX_SLOTS = 1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PAGES   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STACK_FULL = 2'd2;

    // register index as seen on paddr[2]
    localparam logic REG_SLOTS_PER_PAGE = 1'b0;

    typedef struct packed {
        logic load;
        logic exec;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic mem_pop;
    } t_dp_stat;

endpackage

// ===== design/pfla_ram.sv =====
module pfla_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pfla_ctrl.sv =====
module pfla_ctrl import pfla_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output logic     o_busy,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                // a pop at or above the fresh region bound waits in S_READ for the registered ram data
                n_state = i_stat.mem_pop ? S_READ : S_IDLE;
            end
            S_READ: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign o_busy = r_busy;

endmodule

// ===== design/pfla_dp.sv =====
module pfla_dp import pfla_pkg::*; #(
    parameter int STACK_DEPTH = 1024,
    parameter int MAX_PAGES   = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic                 i_cfg_we,
    input  logic [SPP_W-1:0]     i_cfg_data,
    output logic [SPP_W-1:0]     o_spp,
    input  logic                 i_command,
    input  logic [PAGE_W-1:0]    i_free_page,
    input  logic [SLOT_W-1:0]    i_free_slot,
    output logic                 o_done,
    output logic [PAGE_W-1:0]    o_given_page,
    output logic [SLOT_W-1:0]    o_given_slot,
    output logic [CLAIMED_W-1:0] o_pages_claimed,
    output logic [STATUS_W-1:0]  o_status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(MAX_PAGES + 1);

    logic                 r_cmd, n_cmd;
    logic [PAGE_W-1:0]    r_fpage, n_fpage;
    logic [SLOT_W-1:0]    r_fslot, n_fslot;
    logic [FW-1:0]        r_fill, n_fill;
    // entries below r_fresh_lim belong to the last claimed page and hold their own index
    logic [FW-1:0]        r_fresh_lim, n_fresh_lim;
    logic [PAGE_W-1:0]    r_fresh_page, n_fresh_page;
    logic [PW-1:0]        r_pages, n_pages;
    logic [SPP_W-1:0]     r_spp;

    logic                 r_done, n_done;
    logic [PAGE_W-1:0]    r_gpage, n_gpage;
    logic [SLOT_W-1:0]    r_gslot, n_gslot;
    logic [CLAIMED_W-1:0] r_pclaimed, n_pclaimed;
    logic [STATUS_W-1:0]  r_status, n_status;

    logic [SPP_W-1:0]     spp_sat;
    logic [31:0]          eff_n;
    logic [31:0]          eff_m1;
    logic [31:0]          pages_cur;
    logic [31:0]          pages_nxt;
    logic [31:0]          top_idx;
    logic [FW-1:0]        fill_m1;
    logic                 ram_we, ram_re;
    logic [HANDLE_W-1:0]  ram_rdata;

    always_comb begin
        if (r_spp == '0) begin
            spp_sat = SPP_W'(1);
        end else if (r_spp > SPP_W'(MAX_SLOTS)) begin
            spp_sat = SPP_W'(MAX_SLOTS);
        end else begin
            spp_sat = r_spp;
        end
        eff_n = (32'(spp_sat) > 32'(STACK_DEPTH)) ? 32'(STACK_DEPTH) : 32'(spp_sat);
    end

    assign eff_m1    = eff_n - 32'd1;
    assign pages_cur = 32'(r_pages);
    assign pages_nxt = 32'(n_pages);
    assign fill_m1   = r_fill - FW'(1);
    assign top_idx   = 32'(fill_m1);

    assign o_stat.mem_pop = (r_cmd == CMD_ALLOC) && (r_fill != '0) && (fill_m1 >= r_fresh_lim);

    always_comb begin
        n_cmd        = r_cmd;
        n_fpage      = r_fpage;
        n_fslot      = r_fslot;
        n_fill       = r_fill;
        n_fresh_lim  = r_fresh_lim;
        n_fresh_page = r_fresh_page;
        n_pages      = r_pages;
        n_done       = 1'b0;
        n_gpage      = r_gpage;
        n_gslot      = r_gslot;
        n_status     = r_status;
        ram_we       = 1'b0;
        ram_re       = 1'b0;

        if (i_cmd.load) begin
            n_cmd   = i_command;
            n_fpage = i_free_page;
            n_fslot = i_free_slot;
        end

        if (i_cmd.exec) begin
            n_done   = !o_stat.mem_pop;
            n_gpage  = '0;
            n_gslot  = '0;
            n_status = ST_OK;
            if (r_cmd == CMD_ALLOC) begin
                if (r_fill == '0) begin
                    if (r_pages == PW'(MAX_PAGES)) begin
                        n_status = ST_NO_PAGES;
                    end else begin
                        // claim a page: slots 0..n-2 stay implicit, slot n-1 goes out
                        n_pages      = r_pages + PW'(1);
                        n_fill       = FW'(eff_m1);
                        n_fresh_lim  = FW'(eff_m1);
                        n_fresh_page = pages_cur[PAGE_W-1:0];
                        n_gpage      = pages_cur[PAGE_W-1:0];
                        n_gslot      = eff_m1[SLOT_W-1:0];
                    end
                end else begin
                    n_fill = fill_m1;
                    if (fill_m1 < r_fresh_lim) begin
                        n_fresh_lim = fill_m1;
                        n_gpage     = r_fresh_page;
                        n_gslot     = top_idx[SLOT_W-1:0];
                    end else begin
                        ram_re = 1'b1;
                    end
                end
            end else begin
                if (r_fill == FW'(STACK_DEPTH)) begin
                    n_status = ST_STACK_FULL;
                end else begin
                    ram_we = 1'b1;
                    n_fill = r_fill + FW'(1);
                end
            end
        end

        if (i_cmd.finish) begin
            n_done  = 1'b1;
            n_gpage = ram_rdata[HANDLE_W-1:SLOT_W];
            n_gslot = ram_rdata[SLOT_W-1:0];
        end

        n_pclaimed = pages_nxt[CLAIMED_W-1:0];
    end

    pfla_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[AW-1:0]),
        .i_wdata ({r_fpage, r_fslot}),
        .i_re    (ram_re),
        .i_raddr (fill_m1[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_fresh_lim <= '0;
            r_pages     <= '0;
            r_spp       <= SPP_W'(1);
            r_done      <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_fresh_lim <= n_fresh_lim;
            r_pages     <= n_pages;
            r_done      <= n_done;
            if (i_cfg_we) begin
                r_spp <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_fpage      <= n_fpage;
        r_fslot      <= n_fslot;
        r_fresh_page <= n_fresh_page;
        r_gpage      <= n_gpage;
        r_gslot      <= n_gslot;
        r_pclaimed   <= n_pclaimed;
        r_status     <= n_status;
    end

    assign o_spp           = r_spp;
    assign o_done          = r_done;
    assign o_given_page    = r_gpage;
    assign o_given_slot    = r_gslot;
    assign o_pages_claimed = r_pclaimed;
    assign o_status        = r_status;

endmodule

// ===== design/paged_free_list_allocator.sv =====
// channel   | direction | transfer when                  | payload
// request   | in        | start & !busy at clock edge    | i_command, i_free_page, i_free_slot
// result    | out       | o_done high for one cycle      | o_given_page, o_given_slot,
//           |           |                                | o_pages_claimed, o_status
// config    | in        | psel & penable & pwrite edge   | pwdata, reg at paddr 0
//
// o_done rises after the request passes through S_EXEC, and also through S_READ when an allocate
// pops a handle that an earlier free pushed (registered ram read); one request is served at a time:
// busy stays high until the result is shown, then the next request may transfer
// a page claim is done in S_EXEC with no stack writes; its slots are tracked by a fresh-region bound
// synchronous active-low reset; the stack ram needs no clearing pass
// the receiver cannot stall: each result is shown for exactly one cycle
module paged_free_list_allocator import pfla_pkg::*; #(
    parameter int STACK_DEPTH = 1024,
    parameter int MAX_PAGES   = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_command,
    input  logic [PAGE_W-1:0]    i_free_page,
    input  logic [SLOT_W-1:0]    i_free_slot,
    output logic                 o_done,
    output logic [PAGE_W-1:0]    o_given_page,
    output logic [SLOT_W-1:0]    o_given_slot,
    output logic [CLAIMED_W-1:0] o_pages_claimed,
    output logic [STATUS_W-1:0]  o_status,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    logic             cfg_we;
    logic [SPP_W-1:0] spp;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SLOTS_PER_PAGE);
    assign prdata = (paddr[2] == REG_SLOTS_PER_PAGE) ? 32'(spp) : '0;

    pfla_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_busy  (busy),
        .o_cmd   (dp_cmd)
    );

    pfla_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_PAGES   (MAX_PAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (pwdata[SPP_W-1:0]),
        .o_spp           (spp),
        .i_command       (i_command),
        .i_free_page     (i_free_page),
        .i_free_slot     (i_free_slot),
        .o_done          (o_done),
        .o_given_page    (o_given_page),
        .o_given_slot    (o_given_slot),
        .o_pages_claimed (o_pages_claimed),
        .o_status        (o_status)
    );

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("request transfer did not start processing");

    a_error_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> (o_given_page == '0 && o_given_slot == '0))
        else $error("error result carries a handle");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("busy still high with result shown");

endmodule

// ===== bench/tb.sv =====
module tb;
    import pfla_pkg::*;

    localparam int DEPTH       = 1024;
    localparam int PAGES       = 256;
    localparam int STALL_LIMIT = 2000;
    localparam int MIX_ITEMS   = 75;
    localparam int unsigned MIX_SLOTS [6] = '{1, 0, 2, 5, 17, 64};

    typedef struct packed {
        logic              cmd;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic [PAGE_W-1:0]    page;
        logic [SLOT_W-1:0]    slot;
        logic [CLAIMED_W-1:0] claimed;
        logic [STATUS_W-1:0]  status;
    } grant_t;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              i_command   = CMD_ALLOC;
    logic [PAGE_W-1:0] i_free_page = '0;
    logic [SLOT_W-1:0] i_free_slot = '0;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [2:0]        paddr       = '0;
    logic [31:0]       pwdata      = '0;

    logic                 busy;
    logic                 o_done;
    logic [PAGE_W-1:0]    o_given_page;
    logic [SLOT_W-1:0]    o_given_slot;
    logic [CLAIMED_W-1:0] o_pages_claimed;
    logic [STATUS_W-1:0]  o_status;
    logic [31:0]          prdata;
    logic                 pready;

    paged_free_list_allocator #(
        .STACK_DEPTH(DEPTH),
        .MAX_PAGES  (PAGES)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_free_page    (i_free_page),
        .i_free_slot    (i_free_slot),
        .o_done         (o_done),
        .o_given_page   (o_given_page),
        .o_given_slot   (o_given_slot),
        .o_pages_claimed(o_pages_claimed),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the allocator state
    logic [HANDLE_W-1:0] free_handles [DEPTH];
    int unsigned         handle_fill = 0;
    int unsigned         pages_taken = 0;
    logic [SPP_W-1:0]    slots_cfg   = 1;

    req_t        requests_pending [$];
    grant_t      grants_due [$];
    logic [HANDLE_W-1:0] held_handles [$];
    req_t        next_req;
    req_t        seen;
    grant_t      want;
    grant_t      got;
    logic        took        = 1'b0;
    bit          no_gaps     = 1'b0;
    int          errors      = 0;
    int          idle_cycles = 0;

    function automatic grant_t serve_request(req_t r);
        grant_t              g;
        int unsigned         n;
        logic [HANDLE_W-1:0] h;
        g = '0;
        if (r.cmd == CMD_ALLOC) begin
            if (handle_fill == 0) begin
                if (pages_taken >= PAGES) begin
                    g.status = ST_NO_PAGES;
                end else begin
                    n = slots_cfg;
                    if (n < 1) n = 1;
                    if (n > MAX_SLOTS) n = MAX_SLOTS;
                    if (n > DEPTH) n = DEPTH;
                    g.page = PAGE_W'(pages_taken);
                    pages_taken++;
                    // fresh page: slots 0..n-2 stacked, slot n-1 handed out
                    for (int i = 0; i + 1 < n; i++)
                        free_handles[i] = {g.page, SLOT_W'(i)};
                    handle_fill = n - 1;
                    g.slot = SLOT_W'(n - 1);
                end
            end else begin
                handle_fill--;
                h = free_handles[handle_fill];
                g.page = h[HANDLE_W-1:SLOT_W];
                g.slot = h[SLOT_W-1:0];
            end
        end else if (handle_fill >= DEPTH) begin
            g.status = ST_STACK_FULL;
        end else begin
            free_handles[handle_fill] = {r.page, r.slot};
            handle_fill++;
        end
        g.claimed = CLAIMED_W'(pages_taken);
        return g;
    endfunction

    task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!start || took)) begin
            if (requests_pending.size() != 0 && (no_gaps || $urandom_range(99) >= 9)) begin
                next_req = requests_pending.pop_front();
                start       <= 1'b1;
                i_command   <= next_req.cmd;
                i_free_page <= next_req.page;
                i_free_slot <= next_req.slot;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check the result first, then predict a new transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            took <= start && !busy;
            if (o_done) begin
                if (grants_due.size() == 0) begin
                    errors++;
                    $display("%0t: result with no request outstanding", $time);
                end else begin
                    want = grants_due.pop_front();
                    got  = '{o_given_page, o_given_slot, o_pages_claimed, o_status};
                    check_field("given_page", want.page, got.page);
                    check_field("given_slot", want.slot, got.slot);
                    check_field("pages_claimed", want.claimed, got.claimed);
                    check_field("status", want.status, got.status);
                end
            end
            if (start && !busy) begin
                seen = '{i_command, i_free_page, i_free_slot};
                want = serve_request(seen);
                grants_due.insert(grants_due.size(), want);
                if (seen.cmd == CMD_ALLOC && want.status == ST_OK)
                    held_handles.insert(held_handles.size(), {want.page, want.slot});
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_SLOTS_PER_PAGE)
                slots_cfg = pwdata[SPP_W-1:0];
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("paged_free_list_allocator regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic settle();
        while (requests_pending.size() != 0 || grants_due.size() != 0 || start)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic add_req(logic cmd, int page, int slot);
        req_t r;
        r = '{cmd, PAGE_W'(page), SLOT_W'(slot)};
        requests_pending.insert(requests_pending.size(), r);
    endtask

    task automatic add_allocs(int count);
        repeat (count) add_req(CMD_ALLOC, $urandom_range(255), $urandom_range(1023));
    endtask

    task automatic add_mix(int count, int alloc_pct);
        req_t r;
        int   k;
        repeat (count) begin
            r.page = PAGE_W'($urandom_range(255));
            r.slot = SLOT_W'($urandom_range(1023));
            if ($urandom_range(99) < alloc_pct) begin
                r.cmd = CMD_ALLOC;
            end else begin
                r.cmd = CMD_FREE;
                // mostly give back a handle that is out, sometimes a stray one
                if (held_handles.size() != 0 && $urandom_range(3) != 0) begin
                    k = $urandom_range(held_handles.size() - 1);
                    {r.page, r.slot} = held_handles[k];
                    held_handles.delete(k);
                end
            end
            requests_pending.insert(requests_pending.size(), r);
        end
    endtask

    initial begin
        int unsigned spp;
        int          climb;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one slot per page after reset
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_FREE, 255, 1023);
        add_req(CMD_FREE, 0, 0);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_FREE, 'h55, 'h2aa);
        add_req(CMD_FREE, 'haa, 'h155);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_ALLOC, 0, 0);
        settle();

        write_reg(3'd4, 32'd5);     // no register there
        write_reg(3'd0, 32'd3);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_FREE, 7, 9);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_ALLOC, 0, 0);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            spp = (ph == 4) ? $urandom_range(3, 40) : MIX_SLOTS[ph];
            write_reg(3'd0, spp);
            no_gaps = (ph == 2);
            add_mix(MIX_ITEMS, (ph == 5) ? 65 : 55);
            settle();
        end
        no_gaps = 1'b0;

        // drain the stack and claim pages one slot at a time up to the page before the last one
        write_reg(3'd0, 32'd1);
        climb = int'(handle_fill) + PAGES - 1 - int'(pages_taken);
        if (climb > 0)
            add_allocs(climb);
        settle();

        // oversized setting saturates to a full last page, then overflow the stack
        write_reg(3'd0, 32'hffff_ffff);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_FREE, 1, 2);
        add_req(CMD_FREE, 3, 4);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_ALLOC, 0, 0);
        add_req(CMD_FREE, 3, 5);
        add_req(CMD_ALLOC, 0, 0);
        settle();

        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("paged_free_list_allocator regression: pass");
        else
            $display("paged_free_list_allocator regression: fail");
        $finish;
    end
endmodule
